### rtl/led_frame_transition_blender_macros.svh
// Assertion macros shared by the blender RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LED_FRAME_TRANSITION_BLENDER_MACROS_SVH
`define LED_FRAME_TRANSITION_BLENDER_MACROS_SVH

// same-cycle implication
`define LFTB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lftb_pkg.sv
// Types and constants of the LED frame transition blender.
// No dependencies; imported by every blender module.
package lftb_pkg;

   // board geometry
   localparam int PIXEL_COUNT    = 300;
   localparam int PIXELS_PER_ROW = 5;
   localparam int ROW_COUNT      = 60;

   // row = idx / PIXELS_PER_ROW by reciprocal; exact for any 9-bit index
   localparam int ROW_SHIFT = 18;
   localparam int ROW_RECIP = ((1 << ROW_SHIFT) + PIXELS_PER_ROW - 1) / PIXELS_PER_ROW;

   // effect constants
   localparam int RIPPLE_SPAN  = 68;
   localparam int RIPPLE_STEP  = 64;
   localparam int RIPPLE_REACH = 256 / RIPPLE_STEP;
   localparam int TINT_SPLIT   = 64;
   localparam int TINT_REST    = 192;
   localparam int BAND_ROWS    = 5;

   // hash multipliers
   localparam logic [31:0] MIX_MUL_A = 32'h7FEB352D;
   localparam logic [31:0] MIX_MUL_B = 32'h846CA68B;

   localparam logic [31:0] SEED_RESET = 32'h9E3779B9;

   // mode codes
   localparam logic [3:0] MODE_OFF     = 4'd0;
   localparam logic [3:0] MODE_DITHER  = 4'd1;
   localparam logic [3:0] MODE_FADE    = 4'd2;
   localparam logic [3:0] MODE_SPARKLE = 4'd3;
   localparam logic [3:0] MODE_WIPE    = 4'd4;
   localparam logic [3:0] MODE_TINT    = 4'd5;
   localparam logic [3:0] MODE_CDITHER = 4'd6;
   localparam logic [3:0] MODE_CWIPE   = 4'd7;
   localparam logic [3:0] MODE_GLOW    = 4'd8;
   localparam logic [3:0] MODE_RIPPLE  = 4'd9;

   // register indexes
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   typedef struct packed {
      logic [8:0]  idx;
      logic [23:0] old_col;
      logic [23:0] new_col;
      logic [23:0] acc_col;
      logic [8:0]  prog;
   } pix_type;

   // blend job: shown = col_a + (col_b - col_a) * fac / 256 per channel.
   // When use_div is set, fac comes from num * 256 / den.
   typedef struct packed {
      logic [8:0]  idx;
      logic [23:0] col_a;
      logic [23:0] col_b;
      logic [8:0]  fac;
      logic        use_div;
      logic [7:0]  num;
      logic [8:0]  den;
   } job_type;

endpackage

### rtl/lftb_front.sv
// Front end: index hash, row math, accent boosts and effect selection (3 stages).
// Depends on lftb_pkg and the assertion macros header.
`include "led_frame_transition_blender_macros.svh"

module lftb_front import lftb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  mode,
   input  logic [31:0] seed,
   input  logic        in_valid,
   output logic        in_stall,
   input  pix_type     in_pix,
   output logic        out_valid,
   input  logic        out_stall,
   output job_type     out_job
);

   typedef struct packed {
      pix_type     pix;
      logic [31:0] mix;
      logic [8:0]  row;
      logic [7:0]  wipe;
      logic [7:0]  wave;
      logic [23:0] glow;
      logic [23:0] rip;
   } prep_type;

   // floor(c * 8 / 3) clamped at 255
   function automatic logic [7:0] boost_glow(logic [7:0] c);
      logic [25:0] p;
      p = 26'({c, 3'b000}) * 26'(21846);
      return (p[25:16] > 10'd255) ? 8'hFF : p[23:16];
   endfunction

   // floor(c * 3 / 2) clamped at 255
   function automatic logic [7:0] boost_rip(logic [7:0] c);
      logic [9:0] s;
      s = 10'(c) + {1'b0, c, 1'b0};
      return (s[9:1] > 9'd255) ? 8'hFF : s[8:1];
   endfunction

   logic     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   prep_type s1_ff, s1_in, s2_ff, s2_in;
   job_type  s3_ff, s3_in;
   logic     ld1, ld2, ld3;

   assign ld3 = !s3_valid_ff || !out_stall;
   assign ld2 = !s2_valid_ff || ld3;
   assign ld1 = !s1_valid_ff || ld2;
   assign in_stall = !ld1;

   // stage 1: first hash round, row, wipe edge, ripple crest, boosts
   always_comb begin
      logic [31:0] x0;
      logic [27:0] row_p;
      logic [16:0] wipe_p;
      logic [16:0] wave_p;
      x0 = seed + {23'b0, in_pix.idx};
      x0 = x0 ^ (x0 >> 16);
      row_p  = 28'(in_pix.idx) * 28'(ROW_RECIP);
      wipe_p = 17'(ROW_COUNT) * 17'(in_pix.prog[7:0]);
      wave_p = 17'(RIPPLE_SPAN) * 17'(in_pix.prog[7:0]);
      s1_in.pix  = in_pix;
      s1_in.mix  = x0 * MIX_MUL_A;
      s1_in.row  = row_p[ROW_SHIFT +: 9];
      s1_in.wipe = wipe_p[15:8];
      s1_in.wave = wave_p[15:8];
      for (int ch = 0; ch < 3; ch++) begin
         s1_in.glow[ch*8 +: 8] = boost_glow(in_pix.acc_col[ch*8 +: 8]);
         s1_in.rip[ch*8 +: 8]  = boost_rip(in_pix.acc_col[ch*8 +: 8]);
      end
   end

   // stage 2: second hash round
   always_comb begin
      logic [31:0] y;
      y = s1_ff.mix ^ (s1_ff.mix >> 15);
      s2_in = s1_ff;
      s2_in.mix = y * MIX_MUL_B;
   end

   // stage 3: finish hash, pick colors and blend factor
   always_comb begin
      logic [31:0]       h;
      logic [8:0]        t;
      logic              oob;
      logic signed [9:0] rd;
      logic [9:0]        rdist;
      h  = s2_ff.mix ^ (s2_ff.mix >> 16);
      t  = s2_ff.pix.prog;
      oob = 13'(s2_ff.pix.idx) >= 13'(PIXEL_COUNT);
      rd = $signed({1'b0, s2_ff.row}) - $signed({2'b00, s2_ff.wave});
      rdist = (rd < 0) ? 10'(-rd) : 10'(rd);

      s3_in.idx     = s2_ff.pix.idx;
      s3_in.col_a   = s2_ff.pix.new_col;
      s3_in.col_b   = s2_ff.pix.new_col;
      s3_in.fac     = 9'd0;
      s3_in.use_div = 1'b0;
      s3_in.num     = 8'd0;
      s3_in.den     = 9'(TINT_REST);

      if (oob) begin
         s3_in.col_a = 24'd0;
      end else if (!t[8]) begin
         case (mode)
            MODE_DITHER: begin
               if (h[15:0] >= {t[7:0], 8'h00})
                  s3_in.col_a = s2_ff.pix.old_col;
            end
            MODE_FADE: begin
               s3_in.col_a = s2_ff.pix.old_col;
               s3_in.fac   = t;
            end
            MODE_WIPE: begin
               if (s2_ff.row > 9'(s2_ff.wipe))
                  s3_in.col_a = s2_ff.pix.old_col;
            end
            MODE_TINT: begin
               if (t < 9'(TINT_SPLIT)) begin
                  s3_in.col_a = s2_ff.pix.old_col;
                  s3_in.col_b = s2_ff.pix.acc_col;
                  s3_in.fac   = 9'({t[5:0], 2'b00});
               end else begin
                  s3_in.col_a   = s2_ff.pix.acc_col;
                  s3_in.use_div = 1'b1;
                  s3_in.num     = t[7:0] - 8'(TINT_SPLIT);
                  s3_in.den     = 9'(TINT_REST);
               end
            end
            MODE_CDITHER: begin
               if (t[7:0] <= h[7:0]) begin
                  s3_in.col_a = s2_ff.pix.old_col;
               end else begin
                  s3_in.col_a   = s2_ff.pix.acc_col;
                  s3_in.use_div = 1'b1;
                  s3_in.num     = t[7:0] - h[7:0];
                  s3_in.den     = 9'd256 - 9'(h[7:0]);
               end
            end
            MODE_CWIPE: begin
               if (s2_ff.row > 9'(s2_ff.wipe))
                  s3_in.col_a = s2_ff.pix.old_col;
               else if (10'(s2_ff.row) + 10'(BAND_ROWS) > 10'(s2_ff.wipe))
                  s3_in.col_a = s2_ff.pix.acc_col;
            end
            MODE_GLOW: begin
               if (s2_ff.pix.new_col == 24'd0) begin
                  s3_in.col_a = 24'd0;
               end else begin
                  s3_in.col_a = s2_ff.glow;
                  s3_in.fac   = t;
               end
            end
            MODE_RIPPLE: begin
               // near the crest, pull a lit pixel toward the boosted accent
               if (s2_ff.pix.new_col != 24'd0 && rdist < 10'(RIPPLE_REACH)) begin
                  s3_in.col_b = s2_ff.rip;
                  s3_in.fac   = 9'd256 - 9'(RIPPLE_STEP) * rdist[8:0];
               end
            end
            default: begin
               // off, sparkle and unused codes show the new frame
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ld1) s1_valid_ff <= in_valid;
         if (ld2) s2_valid_ff <= s1_valid_ff;
         if (ld3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) s1_ff <= s1_in;
      if (ld2) s2_ff <= s2_in;
      if (ld3) s3_ff <= s3_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_job   = s3_ff;

   `LFTB_ASSERT_IMPL(a_front_oob_black, clock, reset,
      s3_valid_ff && (13'(s3_ff.idx) >= 13'(PIXEL_COUNT)),
      s3_ff.col_a == 24'd0 && s3_ff.fac == 9'd0 && !s3_ff.use_div,
      "pixel beyond the board not forced black")
   `LFTB_ASSERT_IMPL(a_front_fac_range, clock, reset, s3_valid_ff && !s3_ff.use_div,
      !s3_ff.fac[8] || s3_ff.fac[7:0] == 8'd0, "blend factor above 256")
   `LFTB_ASSERT_IMPL(a_front_div_frac, clock, reset, s3_valid_ff && s3_ff.use_div,
      s3_ff.den > {1'b0, s3_ff.num}, "divider numerator not below denominator")

endmodule

### rtl/lftb_divide.sv
// Two-stage restoring divider giving fac = num * 256 / den, four quotient bits a stage.
// Depends on lftb_pkg and the assertion macros header.
`include "led_frame_transition_blender_macros.svh"

module lftb_divide import lftb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   typedef struct packed {
      job_type    job;
      logic [7:0] rem;
      logic [3:0] quo;
   } div_type;

   // one quotient bit: {bit, remainder}
   function automatic logic [8:0] div_step(logic [7:0] rem, logic [8:0] den);
      logic [8:0] r2;
      logic [8:0] diff;
      r2 = {rem, 1'b0};
      diff = r2 - den;
      return (r2 >= den) ? {1'b1, diff[7:0]} : {1'b0, r2[7:0]};
   endfunction

   logic    d1_valid_ff, d2_valid_ff;
   div_type d1_ff, d1_in;
   job_type d2_ff, d2_in;
   logic    ld1, ld2;

   assign ld2 = !d2_valid_ff || !out_stall;
   assign ld1 = !d1_valid_ff || ld2;
   assign in_stall = !ld1;

   always_comb begin
      logic [8:0] st;
      logic [7:0] rem;
      logic [3:0] quo;
      rem = in_job.num;
      quo = 4'd0;
      for (int i = 0; i < 4; i++) begin
         st  = div_step(rem, in_job.den);
         rem = st[7:0];
         quo = {quo[2:0], st[8]};
      end
      d1_in.job = in_job;
      d1_in.rem = rem;
      d1_in.quo = quo;
   end

   always_comb begin
      logic [8:0] st;
      logic [7:0] rem;
      logic [7:0] quo;
      rem = d1_ff.rem;
      quo = {4'd0, d1_ff.quo};
      for (int i = 0; i < 4; i++) begin
         st  = div_step(rem, d1_ff.job.den);
         rem = st[7:0];
         quo = {quo[6:0], st[8]};
      end
      d2_in = d1_ff.job;
      if (d1_ff.job.use_div)
         d2_in.fac = {1'b0, quo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
         d2_valid_ff <= 1'b0;
      end else begin
         if (ld1) d1_valid_ff <= in_valid;
         if (ld2) d2_valid_ff <= d1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) d1_ff <= d1_in;
      if (ld2) d2_ff <= d2_in;
   end

   assign out_valid = d2_valid_ff;
   assign out_job   = d2_ff;

   `LFTB_ASSERT_IMPL(a_div_quo_range, clock, reset, d2_valid_ff && d2_ff.use_div,
      !d2_ff.fac[8], "divided factor reached 256")
   `LFTB_ASSERT_NEXT(a_div_hold, clock, reset, d2_valid_ff && out_stall,
      d2_valid_ff && $stable(d2_ff), "stalled divider beat changed")

endmodule

### rtl/lftb_blend.sv
// Output stage: per-channel lerp of the job's two colors into the result register.
// Depends on lftb_pkg.
module lftb_blend import lftb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  job_type     in_job,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [23:0] out_color,
   output logic [8:0]  out_index
);

   // ca + floor((cb - ca) * f / 256)
   function automatic logic [7:0] blend_ch(logic [7:0] ca, logic [7:0] cb, logic [8:0] f);
      logic signed [9:0]  diff;
      logic signed [19:0] prod;
      logic signed [11:0] sum;
      diff = $signed({2'b00, cb}) - $signed({2'b00, ca});
      prod = diff * $signed({1'b0, f});
      sum  = $signed({4'b0000, ca}) + $signed(prod[19:8]);
      return sum[7:0];
   endfunction

   logic        valid_ff;
   logic [23:0] color_ff, color_in;
   logic [8:0]  index_ff;
   logic        ld;

   assign ld = !valid_ff || !out_stall;
   assign in_stall = !ld;

   always_comb begin
      for (int ch = 0; ch < 3; ch++)
         color_in[ch*8 +: 8] = blend_ch(in_job.col_a[ch*8 +: 8], in_job.col_b[ch*8 +: 8],
                                        in_job.fac);
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (ld)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         color_ff <= color_in;
         index_ff <= in_job.idx;
      end
   end

   assign out_valid = valid_ff;
   assign out_color = color_ff;
   assign out_index = index_ff;

endmodule

### rtl/led_frame_transition_blender.sv
// Top level of the LED frame transition blender: registers and the pixel pipeline.
// Depends on lftb_pkg, lftb_front, lftb_divide and lftb_blend.
//
//   channel | ports  | beat
//   --------+--------+----------------------------------------------------
//   request | req_*  | pixel index, old/new/accent colors, progress
//   result  | rsp_*  | shown color and echoed index
//   config  | csr_*  | write of mode (index 0) or hash seed (index 1)
//
// One pixel per cycle sustained while rsp_stall stays low.
// The depth is set by the two 32x32 hash multipliers (stages 1-2), the selection
// stage, the two-stage factor divider and the lerp in the output register.
// Reset clears the valid bits of every stage, sets mode to off and loads the
// default hash seed.
// A stalled stage holds its beat; empty stages ahead of it still fill.
module led_frame_transition_blender import lftb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_pixel_index,
   input  logic [23:0] req_old_color,
   input  logic [23:0] req_new_color,
   input  logic [23:0] req_accent_color,
   input  logic [8:0]  req_progress,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_shown_color,
   output logic [8:0]  rsp_shown_index,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic [3:0]  mode_ff;
   logic [31:0] seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[3:0];
            CSR_SEED: seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pix_type req_pix;
   assign req_pix.idx     = req_pixel_index;
   assign req_pix.old_col = req_old_color;
   assign req_pix.new_col = req_new_color;
   assign req_pix.acc_col = req_accent_color;
   assign req_pix.prog    = req_progress;

   logic    sel_valid, sel_stall;
   job_type sel_job;
   logic    div_valid, div_stall;
   job_type div_job;

   lftb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .seed      (seed_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_pix    (req_pix),
      .out_valid (sel_valid),
      .out_stall (sel_stall),
      .out_job   (sel_job)
   );

   lftb_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_stall  (sel_stall),
      .in_job    (sel_job),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_job   (div_job)
   );

   lftb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_stall  (div_stall),
      .in_job    (div_job),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_color (rsp_shown_color),
      .out_index (rsp_shown_index)
   );

endmodule

### tb/led_frame_transition_blender_tb.sv
// Self-checking testbench for led_frame_transition_blender: random pixel beats, per-mode sweeps.
// Predicts each shown color with its own blend/hash model; depends on lftb_pkg and the RTL.
module led_frame_transition_blender_tb;
   import lftb_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;

   typedef struct {
      logic [23:0] color;
      logic [8:0]  index;
   } shown_type;

   class blend_scoreboard;
      logic [3:0]  mode;
      logic [31:0] seed;
      shown_type   shown_q[$];
      int          errors;

      function new();
         mode   = MODE_OFF;
         seed   = SEED_RESET;
         errors = 0;
      endfunction

      function int pending();
         return shown_q.size();
      endfunction

      function logic [31:0] mix_hash(logic [31:0] x);
         x = x ^ (x >> 16);
         x = x * MIX_MUL_A;
         x = x ^ (x >> 15);
         x = x * MIX_MUL_B;
         x = x ^ (x >> 16);
         return x;
      endfunction

      // a + floor((b - a) * fac / 256) per channel
      function logic [23:0] lerp_rgb(logic [23:0] a, logic [23:0] b, int fac);
         logic [23:0] res;
         int ca, cb, v;
         res = '0;
         for (int sh = 16; sh >= 0; sh -= 8) begin
            ca = int'(a[sh +: 8]);
            cb = int'(b[sh +: 8]);
            v  = ca + (((cb - ca) * fac) >>> 8);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            res[sh +: 8] = v[7:0];
         end
         return res;
      endfunction

      function logic [23:0] brighten(logic [23:0] c, int num, int den);
         logic [23:0] res;
         int v;
         res = '0;
         for (int sh = 16; sh >= 0; sh -= 8) begin
            v = int'(c[sh +: 8]) * num / den;
            if (v > 255) v = 255;
            res[sh +: 8] = v[7:0];
         end
         return res;
      endfunction

      function logic [23:0] shown_for(pix_type p);
         logic [23:0] res;
         int t, row, front, h, wave, gap_rows, fac;
         t   = int'(p.prog);
         row = int'(p.idx) / PIXELS_PER_ROW;
         res = p.new_col;
         if (int'(p.idx) >= PIXEL_COUNT) begin
            res = '0;
         end else if (t < 256) begin
            case (mode)
               MODE_DITHER: begin
                  h   = int'(mix_hash(seed + 32'(p.idx)) & 32'hFFFF);
                  res = (h < (t << 8)) ? p.new_col : p.old_col;
               end
               MODE_FADE: res = lerp_rgb(p.old_col, p.new_col, t);
               MODE_WIPE: begin
                  front = (ROW_COUNT * t) >> 8;
                  res   = (row <= front) ? p.new_col : p.old_col;
               end
               MODE_TINT: begin
                  if (t < TINT_SPLIT)
                     res = lerp_rgb(p.old_col, p.acc_col, t << 2);
                  else
                     res = lerp_rgb(p.acc_col, p.new_col, ((t - TINT_SPLIT) * 256) / TINT_REST);
               end
               MODE_CDITHER: begin
                  h = int'(mix_hash(seed + 32'(p.idx)) & 32'hFF);
                  if (t <= h)
                     res = p.old_col;
                  else
                     res = lerp_rgb(p.acc_col, p.new_col, ((t - h) * 256) / (256 - h));
               end
               MODE_CWIPE: begin
                  front = (ROW_COUNT * t) >> 8;
                  if (row > front)
                     res = p.old_col;
                  else if (row > front - BAND_ROWS)
                     res = p.acc_col;
                  else
                     res = p.new_col;
               end
               MODE_GLOW: begin
                  res = (p.new_col == 24'd0) ? 24'd0 :
                        lerp_rgb(brighten(p.acc_col, 8, 3), p.new_col, t);
               end
               MODE_RIPPLE: begin
                  wave     = (RIPPLE_SPAN * t) >> 8;
                  gap_rows = row - wave;
                  if (gap_rows < 0) gap_rows = -gap_rows;
                  fac = (gap_rows >= RIPPLE_REACH) ? 0 : 256 - gap_rows * RIPPLE_STEP;
                  if (p.new_col != 24'd0 && fac != 0)
                     res = lerp_rgb(p.new_col, brighten(p.acc_col, 3, 2), fac);
               end
               default: ;   // off, sparkle and unused codes show the new color
            endcase
         end
         return res;
      endfunction

      function void note_pixel(pix_type p);
         shown_type s;
         s.color = shown_for(p);
         s.index = p.idx;
         shown_q.push_back(s);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [23:0] color, logic [8:0] index);
         shown_type want;
         if (shown_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: color %06h index %0d", color, index));
            return;
         end
         want = shown_q.pop_front();
         if (color !== want.color)
            report_mismatch($sformatf("color %06h, want %06h (index %0d, mode %0d)",
                                      color, want.color, want.index, mode));
         if (index !== want.index)
            report_mismatch($sformatf("index %0d, want %0d", index, want.index));
      endtask
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [8:0]  req_pixel_index  = '0;
   logic [23:0] req_old_color    = '0;
   logic [23:0] req_new_color    = '0;
   logic [23:0] req_accent_color = '0;
   logic [8:0]  req_progress     = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [23:0] rsp_shown_color;
   logic [8:0]  rsp_shown_index;
   logic        csr_wr_en        = 1'b0;
   logic        csr_index        = CSR_MODE;
   logic [31:0] csr_wdata        = '0;

   bit sender_idles  = 1'b1;
   bit quiet         = 1'b0;
   bit hold_off_req  = 1'b0;
   int idle_cycles   = 0;

   blend_scoreboard sb = new();

   led_frame_transition_blender DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_index (req_pixel_index),
      .req_old_color   (req_old_color),
      .req_new_color   (req_new_color),
      .req_accent_color(req_accent_color),
      .req_progress    (req_progress),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_shown_color (rsp_shown_color),
      .rsp_shown_index (rsp_shown_index),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic pix_type make_pixel(logic [8:0] idx, logic [23:0] old_col,
                                          logic [23:0] new_col, logic [23:0] acc_col,
                                          logic [8:0] prog);
      pix_type p;
      p.idx     = idx;
      p.old_col = old_col;
      p.new_col = new_col;
      p.acc_col = acc_col;
      p.prog    = prog;
      return p;
   endfunction

   function automatic logic [23:0] random_color();
      case ($urandom_range(0, 15))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic pix_type random_pixel();
      logic [8:0] idx, prog;
      idx = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(PIXEL_COUNT, 511))
                                        : 9'($urandom_range(0, PIXEL_COUNT - 1));
      case ($urandom_range(0, 15))
         0:       prog = 9'($urandom_range(256, 511));
         1:       prog = 9'd0;
         2:       prog = 9'd255;
         default: prog = 9'($urandom_range(0, 255));
      endcase
      return make_pixel(idx, random_color(), random_color(), random_color(), prog);
   endfunction

   // called at a rising edge; returns at the edge that takes the beat, valid left high
   task automatic offer_pixel(input pix_type p);
      if (sender_idles && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_index  <= p.idx;
      req_old_color    <= p.old_col;
      req_new_color    <= p.new_col;
      req_accent_color <= p.acc_col;
      req_progress     <= p.prog;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_pixel(p);
   endtask

   task automatic set_config(input logic [3:0] mode, input logic [31:0] seed);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= {28'd0, mode};
      @(posedge clock);
      csr_index <= CSR_SEED;
      csr_wdata <= seed;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.mode = mode;
      sb.seed = seed;
   endtask

   // receiver side: random stall bursts, one long hold-off on request, none when quiet
   initial begin
      int gap;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off_req = 1'b0;
            @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            // a pending hold-off starts right away, while the sender is still busy
            if (!hold_off_req) begin
               rsp_stall <= 1'b0;
               gap = $urandom_range(1, 30);
               while (gap > 0 && !hold_off_req) begin
                  @(posedge clock);
                  gap--;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_shown_color, rsp_shown_index);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("led_frame_transition_blender test failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] seed_pick;
      wait (reset === 1'b0);
      @(posedge clock);

      // reset config: off mode, landed, last pixel and pixels past the board
      offer_pixel(make_pixel(9'd0,   24'hFFFFFF, 24'h000000, 24'hFFFFFF, 9'd0));
      offer_pixel(make_pixel(9'd299, 24'h123456, 24'hABCDEF, 24'h000000, 9'd256));
      offer_pixel(make_pixel(9'd300, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9'd100));
      offer_pixel(make_pixel(9'd511, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9'd511));

      for (int m = MODE_DITHER; m <= MODE_RIPPLE; m++) begin
         set_config(4'(m), SEED_RESET);
         offer_pixel(make_pixel(9'(5 * m), 24'h000000, 24'hFFFFFF, 24'h80FF40, 9'd128));
         offer_pixel(make_pixel(9'd299, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 9'd255));
      end

      // every mode code, seeds at the extremes and in between
      for (int m = 0; m < 16; m++) begin
         case (m % 3)
            0:       seed_pick = 32'h0000_0000;
            1:       seed_pick = 32'hFFFF_FFFF;
            default: seed_pick = $urandom;
         endcase
         set_config(4'(m), seed_pick);
         repeat (40) offer_pixel(random_pixel());
      end

      for (int k = 0; k < 10; k++) begin
         set_config(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(MODE_DITHER, MODE_RIPPLE)),
                    $urandom);
         sender_idles = (k != 4);
         if (k == 4) hold_off_req = 1'b1;   // back up the pipe while beats keep coming
         if (k >= 8) quiet = 1'b1;
         repeat (36) offer_pixel(random_pixel());
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("led_frame_transition_blender test passed");
      else
         $display("led_frame_transition_blender test failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/lftb_pkg.sv
rtl/lftb_front.sv
rtl/lftb_divide.sv
rtl/lftb_blend.sv
rtl/led_frame_transition_blender.sv
tb/led_frame_transition_blender_tb.sv
